// ===== rtl/core/sorted_event_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// sorted event queue assertion macros
// concurrent checks that vanish when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_QUEUE_CORE_ASSERT_SVH
`define SORTED_EVENT_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define SEQ_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define SEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SEQ_ASSERT_HOLD(lbl, cond, msg)
`define SEQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define SEQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/seq_pkg.sv =====
// ----------------------------------------------------------------------------
// seq_pkg
// shared constants, types and helpers of the sorted event queue
// ----------------------------------------------------------------------------
`default_nettype none

package seq_pkg;

    localparam int CAPACITY   = 64;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int TIME_W     = 32;
    localparam int ID_W       = 32;
    localparam int FUNC_W     = 2;
    localparam int COUNT_W    = 7;
    localparam int ENTRY_W    = TIME_W + ID_W;
    localparam int APB_ADDR_W = 3;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [FUNC_W-1:0] func_t;

    // operation codes
    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_POP    = 2'd1;
    localparam func_t FUNC_REMOVE = 2'd2;
    localparam func_t FUNC_CHECK  = 2'd3;

    // register index (word address bit of paddr, its top bit)
    localparam logic REG_IDX_EPS = 1'b0;
    localparam time_t EPS_RESET  = 32'd16;

    typedef struct packed {
        time_t ev_time;
        id_t   ev_id;
    } entry_t;

    // one result of the engine
    typedef struct packed {
        logic  done;
        time_t res_time;
        id_t   res_id;
        logic  pop_valid;
        logic  insert_ok;
        logic  remove_found;
        logic  is_stable;
        cnt_t  count;
    } res_t;

    // low bits of the count, zero extended where the count is narrower
    function automatic logic [COUNT_W-1:0] count_field(cnt_t c);
        logic [CNT_W+COUNT_W-1:0] ext;
        ext = {{COUNT_W{1'b0}}, c};
        return ext[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/seq_ram.sv =====
// ----------------------------------------------------------------------------
// seq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module seq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/seq_apb.sv =====
// ----------------------------------------------------------------------------
// seq_apb
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
`default_nettype none

module seq_apb (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [seq_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output seq_pkg::time_t                        eps_time
);

    seq_pkg::time_t eps_reg;
    logic           reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[seq_pkg::APB_ADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= seq_pkg::EPS_RESET;
        end
        else if (wr_en && (reg_idx == seq_pkg::REG_IDX_EPS))
        begin
            eps_reg <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == seq_pkg::REG_IDX_EPS)
        begin
            prdata = eps_reg;
        end
    end

    assign eps_time = eps_reg;

endmodule

`default_nettype wire

// ===== rtl/core/seq_engine.sv =====
// ----------------------------------------------------------------------------
// seq_engine
// scan sequencer: reads the sorted store one entry a cycle and shifts in place
// ----------------------------------------------------------------------------
`default_nettype none

module seq_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire seq_pkg::func_t  func,
    input  wire seq_pkg::time_t  event_time,
    input  wire seq_pkg::id_t    triangle_id,
    input  wire seq_pkg::time_t  eps_time,
    output logic                 busy,
    output seq_pkg::res_t        res
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // control
    logic [1:0]       state_reg, state_next;
    seq_pkg::cnt_t    cnt_reg, cnt_next;
    seq_pkg::cnt_t    issue_left_reg, issue_left_next;
    logic             rsp_vld_reg, rsp_vld_next;
    logic             found_reg, found_next;
    logic             unstable_reg, unstable_next;
    seq_pkg::res_t    res_reg, res_next;

    // payload
    seq_pkg::func_t   op_reg, op_next;
    seq_pkg::time_t   key_time_reg, key_time_next;
    seq_pkg::id_t     key_id_reg, key_id_next;
    seq_pkg::addr_t   issue_addr_reg, issue_addr_next;
    seq_pkg::addr_t   rsp_addr_reg, rsp_addr_next;
    seq_pkg::addr_t   last_addr_reg, last_addr_next;
    seq_pkg::addr_t   pos_reg, pos_next;
    seq_pkg::time_t   prev_time_reg, prev_time_next;
    seq_pkg::entry_t  pop_entry_reg, pop_entry_next;

    // ram port
    logic                          ram_we;
    seq_pkg::addr_t                ram_waddr;
    seq_pkg::entry_t               ram_wdata;
    logic                          ram_re;
    logic [seq_pkg::ENTRY_W-1:0]   ram_rdata;
    seq_pkg::entry_t               rsp;

    // scan helpers
    logic             is_last;
    logic             match;
    logic             need_scan;
    seq_pkg::time_t   diff_up;
    seq_pkg::time_t   diff_dn;
    seq_pkg::time_t   diff;
    seq_pkg::addr_t   top_addr;

    seq_ram #(
        .WIDTH (seq_pkg::ENTRY_W),
        .DEPTH (seq_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_addr_reg),
        .rdata (ram_rdata)
    );

    assign rsp      = seq_pkg::entry_t'(ram_rdata);
    assign is_last  = (rsp_addr_reg == last_addr_reg);
    assign diff_up  = rsp.ev_time - prev_time_reg;
    assign diff_dn  = prev_time_reg - rsp.ev_time;
    assign diff     = (rsp.ev_time >= prev_time_reg) ? diff_up : diff_dn;
    assign match    = (op_reg == seq_pkg::FUNC_POP) ? (rsp_addr_reg == '0)
                                                    : (rsp.ev_id == key_id_reg);
    assign top_addr = seq_pkg::addr_t'(cnt_reg - seq_pkg::cnt_t'(1));
    assign need_scan = (cnt_reg != '0) &&
                       !((func == seq_pkg::FUNC_INSERT) &&
                         (cnt_reg == seq_pkg::cnt_t'(seq_pkg::CAPACITY)));

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        issue_left_next = issue_left_reg;
        rsp_vld_next    = 1'b0;
        found_next      = found_reg;
        unstable_next   = unstable_reg;
        res_next        = res_reg;
        res_next.done   = 1'b0;

        op_next         = op_reg;
        key_time_next   = key_time_reg;
        key_id_next     = key_id_reg;
        issue_addr_next = issue_addr_reg;
        rsp_addr_next   = rsp_addr_reg;
        last_addr_next  = last_addr_reg;
        pos_next        = pos_reg;
        prev_time_next  = prev_time_reg;
        pop_entry_next  = pop_entry_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next         = func;
                    key_time_next   = event_time;
                    key_id_next     = triangle_id;
                    found_next      = 1'b0;
                    unstable_next   = 1'b0;
                    pos_next        = '0;
                    issue_left_next = cnt_reg;
                    if (func == seq_pkg::FUNC_INSERT)
                    begin
                        // walk down from the tail, shifting larger times up
                        issue_addr_next = top_addr;
                        last_addr_next  = '0;
                    end
                    else
                    begin
                        issue_addr_next = '0;
                        last_addr_next  = top_addr;
                    end
                    state_next = need_scan ? ST_SCAN : ST_FINISH;
                end
            end

            ST_SCAN:
            begin
                // issue side
                if (issue_left_reg != '0)
                begin
                    ram_re          = 1'b1;
                    rsp_vld_next    = 1'b1;
                    rsp_addr_next   = issue_addr_reg;
                    issue_left_next = issue_left_reg - seq_pkg::cnt_t'(1);
                    if (op_reg == seq_pkg::FUNC_INSERT)
                    begin
                        issue_addr_next = issue_addr_reg - seq_pkg::addr_t'(1);
                    end
                    else
                    begin
                        issue_addr_next = issue_addr_reg + seq_pkg::addr_t'(1);
                    end
                end

                // response side, writes always land away from the read pointer
                if (rsp_vld_reg)
                begin
                    unique case (op_reg)
                        seq_pkg::FUNC_INSERT:
                        begin
                            if (rsp.ev_time > key_time_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = rsp_addr_reg + seq_pkg::addr_t'(1);
                                ram_wdata = rsp;
                                if (is_last)
                                begin
                                    state_next = ST_FINISH;
                                end
                            end
                            else
                            begin
                                pos_next   = rsp_addr_reg + seq_pkg::addr_t'(1);
                                state_next = ST_FINISH;
                            end
                        end

                        seq_pkg::FUNC_POP, seq_pkg::FUNC_REMOVE:
                        begin
                            if (found_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = rsp_addr_reg - seq_pkg::addr_t'(1);
                                ram_wdata = rsp;
                            end
                            else if (match)
                            begin
                                found_next     = 1'b1;
                                pop_entry_next = rsp;
                            end
                            if (is_last)
                            begin
                                state_next = ST_FINISH;
                            end
                        end

                        seq_pkg::FUNC_CHECK:
                        begin
                            prev_time_next = rsp.ev_time;
                            if ((rsp_addr_reg != '0) && (diff < eps_time))
                            begin
                                unstable_next = 1'b1;
                                state_next    = ST_FINISH;
                            end
                            else if (is_last)
                            begin
                                state_next = ST_FINISH;
                            end
                        end

                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_FINISH:
            begin
                res_next.done         = 1'b1;
                res_next.res_time     = '0;
                res_next.res_id       = '0;
                res_next.pop_valid    = 1'b0;
                res_next.insert_ok    = 1'b0;
                res_next.remove_found = 1'b0;
                res_next.is_stable    = 1'b0;

                unique case (op_reg)
                    seq_pkg::FUNC_INSERT:
                    begin
                        if (cnt_reg != seq_pkg::cnt_t'(seq_pkg::CAPACITY))
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = pos_reg;
                            ram_wdata.ev_time  = key_time_reg;
                            ram_wdata.ev_id    = key_id_reg;
                            cnt_next           = cnt_reg + seq_pkg::cnt_t'(1);
                            res_next.insert_ok = 1'b1;
                        end
                    end

                    seq_pkg::FUNC_POP:
                    begin
                        if (found_reg)
                        begin
                            cnt_next           = cnt_reg - seq_pkg::cnt_t'(1);
                            res_next.pop_valid = 1'b1;
                            res_next.res_time  = pop_entry_reg.ev_time;
                            res_next.res_id    = pop_entry_reg.ev_id;
                        end
                    end

                    seq_pkg::FUNC_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            cnt_next              = cnt_reg - seq_pkg::cnt_t'(1);
                            res_next.remove_found = 1'b1;
                        end
                    end

                    seq_pkg::FUNC_CHECK:
                    begin
                        res_next.is_stable = !unstable_reg;
                    end

                    default:
                    begin
                        res_next.is_stable = 1'b0;
                    end
                endcase

                res_next.count = cnt_next;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            issue_left_reg <= '0;
            rsp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            unstable_reg   <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            issue_left_reg <= issue_left_next;
            rsp_vld_reg    <= rsp_vld_next;
            found_reg      <= found_next;
            unstable_reg   <= unstable_next;
            res_reg        <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_time_reg   <= key_time_next;
        key_id_reg     <= key_id_next;
        issue_addr_reg <= issue_addr_next;
        rsp_addr_reg   <= rsp_addr_next;
        last_addr_reg  <= last_addr_next;
        pos_reg        <= pos_next;
        prev_time_reg  <= prev_time_next;
        pop_entry_reg  <= pop_entry_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign res  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_event_queue_core
// time-ordered event queue with insert, pop, remove by id and stability check
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; its one result shows
// on the result ports for a single cycle with done high, and the receiver has
// no way to hold it off, so it must take every result as it comes. the events
// sit in one ram that is walked one entry per cycle through its single read
// port, at most once over the stored events per request; an insert into a
// full queue and any request on an empty queue skip the walk. the next
// request can be taken in the same cycle that done is shown. eps_time must
// be written over apb only while the queue is idle; the block itself does
// not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_event_queue_core_assert.svh"

module sorted_event_queue_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [seq_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,

    // request side
    input  wire logic                            start,
    input  wire logic [1:0]                      func,
    input  wire logic [31:0]                     event_time,
    input  wire logic [31:0]                     triangle_id,
    output logic                                 busy,

    // result side
    output logic                                 done,
    output logic      [31:0]                     result_time,
    output logic      [31:0]                     result_id,
    output logic                                 pop_valid,
    output logic                                 insert_ok,
    output logic                                 remove_found,
    output logic                                 is_stable,
    output logic      [6:0]                      entry_count
);

    seq_pkg::time_t eps_time;
    seq_pkg::res_t  eng_res;

    // eps_time register
    seq_apb u_apb (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .eps_time (eps_time)
    );

    // scan sequencer around the event ram
    seq_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .event_time  (event_time),
        .triangle_id (triangle_id),
        .eps_time    (eps_time),
        .busy        (busy),
        .res         (eng_res)
    );

    // result fields come straight from the engine's output register
    assign done         = eng_res.done;
    assign result_time  = eng_res.res_time;
    assign result_id    = eng_res.res_id;
    assign pop_valid    = eng_res.pop_valid;
    assign insert_ok    = eng_res.insert_ok;
    assign remove_found = eng_res.remove_found;
    assign is_stable    = eng_res.is_stable;
    // count reported as its low bits
    assign entry_count  = seq_pkg::count_field(eng_res.count);

    // an accepted request always starts work on the next cycle
    `SEQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but engine idle")

    // one result per request, never two in a row
    `SEQ_ASSERT_NEXT(a_done_gap, done, !done, "result strobe held for two cycles")

    // at most one outcome flag per result
    `SEQ_ASSERT_IMPL(a_flags_onehot, done,
        $onehot0({pop_valid, insert_ok, remove_found, is_stable}),
        "more than one outcome flag set")

    // the stored count never passes the queue depth
    `SEQ_ASSERT_HOLD(a_count_bound,
        eng_res.count <= seq_pkg::cnt_t'(seq_pkg::CAPACITY),
        "entry count beyond queue depth")

endmodule

`default_nettype wire
